// ===== src/sfc_pkg.sv =====
// shared constants, types and the crc step function for the scope frame encoder
`timescale 1ns / 1ps

package sfc_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_W    = 16;
    localparam int BYTE_W      = 8;
    localparam int PAYLOAD_LEN = 2 * CHANNELS;
    localparam int FRAME_LEN   = PAYLOAD_LEN + 2;
    localparam int IDX_W       = $clog2(FRAME_LEN);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // channel 0 sits in the low bits, so shifting right walks the frame order
    typedef logic [CHANNELS*SAMPLE_W-1:0] t_samples;

    // one byte of the reflected modbus crc, bit by bit
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [BYTE_W-1:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== src/scope_frame_crc16_encoder.sv =====
// top level: sample word buffer feeding the crc16 frame serializer
//
//  channel  dir  handshake         payload
//  input    in   i_valid/o_stall   i_sample_a..i_sample_d, 16 bits each
//  output   out  o_valid/i_stall   o_frame_byte (8 bits), o_frame_end
//
// each sample word becomes a 10-byte frame, one byte per cycle on the output
// while the output does not stall; the serializer loads the next word as the
// last byte of a frame enters its byte-wide output register, and the crc
// advances one byte per payload byte alongside it in the serializer
// reset (synchronous, active low) empties the buffer and the serializer
// output stalls hold the current byte; the input stalls only while the
// one-word buffer is full
`timescale 1ns / 1ps

module scope_frame_crc16_encoder
    import sfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [SAMPLE_W-1:0] i_sample_a,
    input  logic [SAMPLE_W-1:0] i_sample_b,
    input  logic [SAMPLE_W-1:0] i_sample_c,
    input  logic [SAMPLE_W-1:0] i_sample_d,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_frame_byte,
    output logic              o_frame_end
);

    // one-word buffer so a new word can be taken while a frame is going out
    logic     r_buf_vld, n_buf_vld;
    t_samples r_buf;
    logic     in_accept;
    logic     load_rdy;

    assign o_stall   = r_buf_vld;
    assign in_accept = i_valid && !r_buf_vld;

    always_comb begin
        n_buf_vld = r_buf_vld;
        if (r_buf_vld && load_rdy) begin
            n_buf_vld = 1'b0;
        end
        if (in_accept) begin
            n_buf_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_vld <= 1'b0;
        end else begin
            r_buf_vld <= n_buf_vld;
        end
    end

    // channel a in the low bits: it leaves first
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_buf <= {i_sample_d, i_sample_c, i_sample_b, i_sample_a};
        end
    end

    sfc_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_vld   (r_buf_vld),
        .i_samples    (r_buf),
        .o_load_rdy   (load_rdy),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end)
    );

endmodule

// ===== src/sfc_serializer.sv =====
// frame serializer: sample bytes low first, running crc, then crc low and high
`timescale 1ns / 1ps

module sfc_serializer
    import sfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load_vld,
    input  t_samples          i_samples,
    output logic              o_load_rdy,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_frame_byte,
    output logic              o_frame_end
);

    localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(PAYLOAD_LEN);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

    logic              r_act,  n_act;
    logic [IDX_W-1:0]  r_idx,  n_idx;
    logic [15:0]       r_crc,  n_crc;
    t_samples          r_data, n_data;
    logic              r_out_vld,  n_out_vld;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_end,  n_out_end;

    logic out_adv;
    logic load_rdy;

    assign out_adv  = !r_out_vld || !i_stall;
    assign load_rdy = !r_act || (out_adv && (r_idx == IDX_LAST));

    always_comb begin
        n_act      = r_act;
        n_idx      = r_idx;
        n_crc      = r_crc;
        n_data     = r_data;
        n_out_vld  = r_out_vld;
        n_out_byte = r_out_byte;
        n_out_end  = r_out_end;

        if (out_adv) begin
            n_out_vld = r_act;
            if (r_act) begin
                if (r_idx < IDX_CRC_LO) begin
                    n_out_byte = r_data[BYTE_W-1:0];
                    n_crc      = crc16_byte(r_crc, r_data[BYTE_W-1:0]);
                    n_data     = r_data >> BYTE_W;
                end else if (r_idx == IDX_CRC_LO) begin
                    n_out_byte = r_crc[7:0];
                end else begin
                    n_out_byte = r_crc[15:8];
                end
                n_out_end = (r_idx == IDX_LAST);
                n_idx     = r_idx + 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_act = 1'b0;
                end
            end
        end

        // next frame is loaded in the cycle the last byte enters the output register
        if (i_load_vld && load_rdy) begin
            n_act  = 1'b1;
            n_idx  = '0;
            n_crc  = CRC_INIT;
            n_data = i_samples;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_act     <= n_act;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc      <= n_crc;
        r_data     <= n_data;
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
    end

    assign o_load_rdy   = load_rdy;
    assign o_valid      = r_out_vld;
    assign o_frame_byte = r_out_byte;
    assign o_frame_end  = r_out_end;

endmodule
